@@ sv/ookrx_pkg.sv @@
package ookrx_pkg;

	localparam int MAX_PAIRS = 8;
	localparam int MSG_LEN   = 10;
	localparam int PV_W      = $clog2(MAX_PAIRS + 1);
	localparam int IDX_W     = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;

	localparam logic [7:0] CMD_OFF    = 8'hF6;
	localparam logic [7:0] CMD_ON     = 8'hEE;
	localparam logic [7:0] CMD_MOOD   = 8'hED;
	localparam logic [7:0] PAR_ALLOFF = 8'h7D;
	localparam logic [7:0] DEV_ALL    = 8'h6F;

	localparam logic [1:0] ACT_EDGE   = 2'd0;
	localparam logic [1:0] ACT_WINDOW = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_MSG  = 2'd1;
	localparam logic [1:0] PH_BYTE = 2'd2;
	localparam logic [1:0] PH_GET  = 2'd3;

	localparam logic [3:0] EV_SHORT_HI = 4'd2;
	localparam logic [3:0] EV_ONE      = 4'd3;
	localparam logic [3:0] EV_ZERO     = 4'd5;
	localparam logic [3:0] EV_START    = 4'd7;
	localparam logic [3:0] EV_ILLEGAL  = 4'd8;

	localparam logic [15:0] T_SHORT = 16'd120;
	localparam logic [15:0] T_MID   = 16'd500;
	localparam logic [15:0] T_LONG  = 16'd2000;
	localparam logic [15:0] T_GAP   = 16'd5000;
	localparam logic [31:0] MS_UNIT = 32'd100;

	localparam logic [1:0] REG_REPEATS = 2'd0;
	localparam logic [1:0] REG_TIMEOUT = 2'd1;
	localparam logic [1:0] REG_ENFORCE = 2'd2;
	localparam logic [1:0] REG_BASE    = 2'd3;

	typedef struct packed {
		logic load_in;
		logic decode;
		logic finish;
		logic add_write;
		logic pv_inc;
		logic pv_dec;
		logic scan_init;
		logic scan_all;
		logic scan_rd;
		logic scan_dec;
		logic sh_rd;
		logic sh_wr;
		logic rep_set;
		logic rep_val;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic pkt_done;
		logic act;
		logic do_add;
		logic do_rem;
		logic pv_zero;
		logic pv_full;
		logic match;
		logic idx_zero;
		logic sh_more;
		logic all_dev;
		logic enforce;
	} sts_t;

	function automatic logic [3:0] classify(input logic level, input logic [15:0] dur);
		logic [3:0] ev;
		ev = {3'd0, level};
		if (dur < T_SHORT) begin
			ev = {3'd0, level};
		end else if (dur < T_MID) begin
			ev = 4'd2 + {3'd0, level};
		end else if (dur < T_LONG) begin
			ev = 4'd4 + {3'd0, level};
		end else if (dur > T_GAP) begin
			ev = 4'd6 + {3'd0, level};
		end else begin
			ev = EV_ILLEGAL;
		end
		return ev;
	endfunction

endpackage

@@ sv/ookrx_ctrl.sv @@
module ookrx_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	output logic            m_tvalid,
	input  logic            m_tready,
	input  ookrx_pkg::sts_t sts,
	output ookrx_pkg::cmd_t cmd
);
	import ookrx_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_FINISH = 4'd2;
	localparam logic [3:0] S_ROUTE  = 4'd3;
	localparam logic [3:0] S_ADD    = 4'd4;
	localparam logic [3:0] S_RD     = 4'd5;
	localparam logic [3:0] S_CMP    = 4'd6;
	localparam logic [3:0] S_SH_RD  = 4'd7;
	localparam logic [3:0] S_SH_WR  = 4'd8;
	localparam logic [3:0] S_REPORT = 4'd9;
	localparam logic [3:0] S_OUT    = 4'd10;

	localparam logic [1:0] P_ADD = 2'd0;
	localparam logic [1:0] P_REM = 2'd1;
	localparam logic [1:0] P_REP = 2'd2;

	logic [3:0] state_q, state_d;
	logic [1:0] purpose_q, purpose_d;
	logic       mvalid_q, mvalid_d;

	always_comb begin
		state_d   = state_q;
		purpose_d = purpose_q;
		mvalid_d  = mvalid_q;
		cmd       = '0;
		s_tready  = 1'b0;
		if (mvalid_q && m_tready) begin
			mvalid_d = 1'b0;
		end
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.decode = 1'b1;
				state_d    = sts.pkt_done ? S_FINISH : S_OUT;
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = S_ROUTE;
			end
			S_ROUTE: begin
				if (!sts.act) begin
					state_d = S_OUT;
				end else if (sts.do_add) begin
					state_d = sts.pv_full ? S_REPORT : S_ADD;
				end else if (sts.do_rem && !sts.pv_zero) begin
					cmd.scan_init = 1'b1;
					purpose_d     = P_REM;
					state_d       = S_RD;
				end else begin
					state_d = S_REPORT;
				end
			end
			S_ADD: begin
				cmd.add_write = 1'b1;
				if (sts.pv_zero) begin
					cmd.pv_inc = 1'b1;
					state_d    = S_REPORT;
				end else begin
					cmd.scan_init = 1'b1;
					purpose_d     = P_ADD;
					state_d       = S_RD;
				end
			end
			S_RD: begin
				cmd.scan_rd = 1'b1;
				state_d     = S_CMP;
			end
			S_CMP: begin
				if (sts.match) begin
					unique case (purpose_q)
						P_ADD:   state_d = S_REPORT;
						P_REM:   state_d = S_SH_RD;
						default: begin
							cmd.rep_set = 1'b1;
							cmd.rep_val = 1'b1;
							state_d     = S_OUT;
						end
					endcase
				end else if (sts.idx_zero) begin
					unique case (purpose_q)
						P_ADD: begin
							cmd.pv_inc = 1'b1;
							state_d    = S_REPORT;
						end
						P_REM:   state_d = S_REPORT;
						default: begin
							cmd.rep_set = 1'b1;
							state_d     = S_OUT;
						end
					endcase
				end else begin
					cmd.scan_dec = 1'b1;
					state_d      = S_RD;
				end
			end
			S_SH_RD: begin
				if (sts.sh_more) begin
					cmd.sh_rd = 1'b1;
					state_d   = S_SH_WR;
				end else begin
					cmd.pv_dec = 1'b1;
					state_d    = S_REPORT;
				end
			end
			S_SH_WR: begin
				cmd.sh_wr = 1'b1;
				state_d   = S_SH_RD;
			end
			S_REPORT: begin
				if (sts.pv_zero) begin
					cmd.rep_set = 1'b1;
					cmd.rep_val = !sts.enforce;
					state_d     = S_OUT;
				end else begin
					cmd.scan_init = 1'b1;
					cmd.scan_all  = sts.all_dev;
					purpose_d     = P_REP;
					state_d       = S_RD;
				end
			end
			S_OUT: begin
				if (!mvalid_q || m_tready) begin
					cmd.out_load = 1'b1;
					mvalid_d     = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			purpose_q <= P_ADD;
			mvalid_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			purpose_q <= purpose_d;
			mvalid_q  <= mvalid_d;
		end
	end

	assign m_tvalid = mvalid_q;

endmodule

@@ sv/ookrx_dp.sv @@
module ookrx_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [1:0]      s_tuser,
	input  logic [63:0]     s_tdata,
	output logic [87:0]     m_tdata,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [3:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	input  ookrx_pkg::cmd_t cmd,
	output ookrx_pkg::sts_t sts
);
	import ookrx_pkg::*;

	logic [7:0] repeats_q, timeout_q;
	logic       enforce_q, base_q;

	logic [1:0]  action_q;
	logic        level_q;
	logic [15:0] dur_q;
	logic [31:0] now_q;
	logic [7:0]  win_q;

	logic [1:0]                  phase_q;
	logic [3:0]                  bitc_q, bytec_q;
	logic [MSG_LEN-1:0][7:0]     rx_q, last_q;
	logic [7:0]                  repc_q;
	logic [31:0]                 lpt_q, pst_q;
	logic [7:0]                  pwl_q;
	logic [PV_W-1:0]             pv_q;
	logic [IDX_W-1:0]            idx_q;
	logic                        scan_all_q;
	logic [63:0]                 rdata_q;
	logic                        done_q, rep_q, act_q, do_add_q, do_rem_q;
	logic [87:0]                 out_q;
	logic [63:0]                 mem [MAX_PAIRS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeats_q <= 8'd2;
			timeout_q <= 8'd20;
			enforce_q <= 1'b0;
			base_q    <= 1'b0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_REPEATS: repeats_q <= pwdata[7:0];
				REG_TIMEOUT: timeout_q <= pwdata[7:0];
				REG_ENFORCE: enforce_q <= pwdata[0];
				default:     base_q    <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_REPEATS: prdata = {24'd0, repeats_q};
			REG_TIMEOUT: prdata = {24'd0, timeout_q};
			REG_ENFORCE: prdata = {31'd0, enforce_q};
			default:     prdata = {31'd0, base_q};
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			action_q <= s_tuser;
			level_q  <= s_tdata[0];
			dur_q    <= s_tdata[16:1];
			now_q    <= s_tdata[48:17];
			win_q    <= s_tdata[56:49];
		end
	end

	logic [3:0] ev, bi, bitc_n, bitc_d, bytec_d;
	logic [1:0] phase_d;
	logic [7:0] cur, byte_d;
	logic       byte_wr, pkt_done;

	always_comb begin
		ev       = classify(level_q, dur_q);
		bi       = (bytec_q < 4'(MSG_LEN)) ? bytec_q : 4'd0;
		cur      = rx_q[bi];
		phase_d  = phase_q;
		bitc_n   = bitc_q;
		bitc_d   = bitc_q;
		bytec_d  = bytec_q;
		byte_d   = cur;
		byte_wr  = 1'b0;
		pkt_done = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (ev == EV_START) phase_d = PH_MSG;
			end
			PH_MSG: begin
				if (ev == EV_ONE) begin
					bytec_d = 4'd0;
					phase_d = PH_BYTE;
				end else if (ev != EV_SHORT_HI) begin
					phase_d = PH_IDLE;
				end
			end
			PH_BYTE: begin
				if (ev == EV_ONE) begin
					phase_d = PH_GET;
					bitc_d  = 4'd0;
				end else if (ev == EV_ZERO) begin
					phase_d = PH_GET;
					bitc_d  = 4'd1;
					byte_d  = 8'd0;
					byte_wr = 1'b1;
				end else if (ev != EV_SHORT_HI) begin
					phase_d = PH_IDLE;
				end
			end
			default: begin
				if (ev == EV_ONE) begin
					byte_d  = {cur[6:0], 1'b1};
					byte_wr = 1'b1;
					bitc_n  = bitc_q + 4'd1;
				end else if (ev == EV_ZERO) begin
					byte_d  = {cur[5:0], 2'b10};
					byte_wr = 1'b1;
					bitc_n  = bitc_q + 4'd2;
				end else if (ev != EV_SHORT_HI) begin
					phase_d = PH_IDLE;
				end
				bitc_d = bitc_n;
				if (bitc_n >= 4'd8) begin
					bytec_d = bi + 4'd1;
					bitc_d  = 4'd0;
					if (bi + 4'd1 >= 4'(MSG_LEN)) begin
						pkt_done = 1'b1;
						phase_d  = PH_IDLE;
					end else begin
						phase_d = PH_BYTE;
					end
				end
			end
		endcase
	end

	logic        edge_act, same, expired, win_ok, pass, all_dev, match;
	logic [31:0] rep_lim, win_lim, age, pair_age;
	logic [7:0]  repc_d, mask;

	always_comb begin
		edge_act = (action_q == ACT_EDGE);
		same     = (rx_q == last_q);
		age      = now_q - lpt_q;
		pair_age = now_q - pst_q;
		rep_lim  = (32'(timeout_q) + 32'd1) * MS_UNIT;
		win_lim  = (32'(pwl_q) + 32'd1) * MS_UNIT;
		expired  = (age >= rep_lim);
		win_ok   = (pwl_q != 8'd0) && (pair_age < win_lim);
		if (repeats_q == 8'd0) begin
			repc_d = 8'd0;
		end else if (expired || !same) begin
			repc_d = 8'd1;
		end else begin
			repc_d = repc_q + 8'd1;
		end
		pass    = (repeats_q == 8'd0) || (repc_d == repeats_q);
		all_dev = (last_q[3] == CMD_MOOD && last_q[2] == DEV_ALL) ||
		          (last_q[3] == CMD_OFF && last_q[0] == PAR_ALLOFF);
		if (base_q) begin
			mask = 8'b0111_1100;
		end else begin
			mask = scan_all_q ? 8'b1111_1100 : 8'b1111_1101;
		end
		match = 1'b1;
		for (int j = 0; j < 8; j++) begin
			if (mask[j] && rdata_q[8*j +: 8] != last_q[2+j]) match = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			bitc_q     <= 4'd0;
			bytec_q    <= 4'd0;
			rx_q       <= '0;
			last_q     <= '0;
			repc_q     <= 8'd0;
			lpt_q      <= 32'd0;
			pst_q      <= 32'd0;
			pwl_q      <= 8'd0;
			pv_q       <= '0;
			idx_q      <= '0;
			scan_all_q <= 1'b0;
			done_q     <= 1'b0;
			rep_q      <= 1'b0;
			act_q      <= 1'b0;
			do_add_q   <= 1'b0;
			do_rem_q   <= 1'b0;
		end else begin
			if (cmd.decode) begin
				done_q <= edge_act && pkt_done;
				rep_q  <= 1'b0;
				if (edge_act) begin
					phase_q <= phase_d;
					bitc_q  <= bitc_d;
					bytec_q <= bytec_d;
					if (byte_wr) rx_q[bi] <= byte_d;
				end else if (action_q == ACT_WINDOW) begin
					pwl_q <= win_q;
					pst_q <= now_q;
				end else if (action_q == ACT_CLEAR) begin
					pv_q <= '0;
				end
			end
			if (cmd.finish) begin
				repc_q   <= repc_d;
				lpt_q    <= now_q;
				last_q   <= rx_q;
				act_q    <= pass;
				do_add_q <= pass && win_ok && rx_q[3] == CMD_ON;
				do_rem_q <= pass && win_ok && rx_q[3] == CMD_OFF;
				if (pass) pwl_q <= 8'd0;
			end
			if (cmd.pv_inc) pv_q <= pv_q + PV_W'(1);
			if (cmd.pv_dec) pv_q <= pv_q - PV_W'(1);
			if (cmd.scan_init) begin
				idx_q      <= IDX_W'(pv_q - PV_W'(1));
				scan_all_q <= cmd.scan_all;
			end
			if (cmd.scan_dec) idx_q <= idx_q - IDX_W'(1);
			if (cmd.sh_wr) idx_q <= idx_q + IDX_W'(1);
			if (cmd.rep_set) rep_q <= cmd.rep_val;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add_write) begin
			mem[IDX_W'(pv_q)] <= last_q[9:2];
		end else if (cmd.sh_wr) begin
			mem[idx_q] <= rdata_q;
		end
		if (cmd.scan_rd) begin
			rdata_q <= mem[idx_q];
		end else if (cmd.sh_rd) begin
			rdata_q <= mem[idx_q + IDX_W'(1)];
		end
	end

	logic [31:0] pv32;
	logic [63:0] head;

	assign pv32 = 32'(pv_q);
	assign head = {last_q[0], last_q[1], last_q[2], last_q[3],
	               last_q[4], last_q[5], last_q[6], last_q[7]};

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q <= {2'd0, pv32[3:0], last_q[8], last_q[9], head, rep_q, done_q};
		end
	end

	assign m_tdata = out_q;

	assign sts.pkt_done = edge_act && pkt_done;
	assign sts.act      = act_q;
	assign sts.do_add   = do_add_q;
	assign sts.do_rem   = do_rem_q;
	assign sts.pv_zero  = (pv_q == '0);
	assign sts.pv_full  = (pv32 >= 32'(MAX_PAIRS));
	assign sts.match    = match;
	assign sts.idx_zero = (idx_q == '0);
	assign sts.sh_more  = (32'(idx_q) + 32'd1) < pv32;
	assign sts.all_dev  = all_dev;
	assign sts.enforce  = enforce_q;

endmodule

@@ sv/ook_pulse_packet_receiver.sv @@
// Channel   Direction  Contents
// s_*       in         request: tuser action, tdata level, duration_us, time_ms, pair_window
// m_*       out        result: packet_done, reported, msg_head, msg_tail, pair_count
// APB       in/out     four configuration registers at byte addresses 0, 4, 8 and 12
//
// An edge that completes no packet goes from acceptance through the decode state to the output state.
// A completed packet also passes the finish and route states and may scan or shift the pairing
// table entry by entry; the table has one read port.
// Reset clears all control state at once; the pairing table needs no clearing pass.
// A new request is taken as soon as the previous result is in the output register.
module ook_pulse_packet_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,  // action
	input  logic [63:0] s_tdata,  // level, duration_us, time_ms, pair_window, zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,  // packet_done, reported, msg_head, msg_tail, pair_count, zero fill
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ookrx_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign pready = 1'b1;

	ookrx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ookrx_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tuser (s_tuser),
		.s_tdata (s_tdata),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cmd     (cmd),
		.sts     (sts)
	);

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import ookrx_pkg::*;

	typedef struct {
		logic [1:0]  action;
		logic        level;
		logic [15:0] dur;
		logic [31:0] tms;
		logic [7:0]  win;
	} edge_req_t;

	typedef struct packed {
		logic [3:0]  cnt;
		logic [15:0] tail;
		logic [63:0] head;
		logic        rep;
		logic        done;
	} rx_result_t;

	typedef logic [7:0] key_t [8];

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [1:0]  s_tuser = '0;
	logic [63:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [87:0] m_tdata;
	logic        psel = 0;
	logic        penable = 0;
	logic        pwrite = 0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	ook_pulse_packet_receiver i_dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	edge_req_t  pending_reqs[$];
	rx_result_t expected_results[$];
	edge_req_t  drv_req;
	int         errors = 0;
	int         accepted = 0;
	int         packets_seen = 0;
	int         packets_reported = 0;
	int         max_pairs_seen = 0;
	int         cycles = 0;
	int         gap_left = 0;
	int         burst_left = 0;
	int         stall_mode = 0;
	logic [31:0] now_ms;
	logic [7:0] dev_pool [4][10];
	int         ev_list[$];

	// Receiver model state and configuration.
	logic [7:0]  cfg_repeats, cfg_timeout;
	logic        cfg_enforce, cfg_base;
	logic [1:0]  phase;
	int          bit_cnt, byte_cnt, pairs;
	logic [7:0]  rx_bytes [10];
	logic [7:0]  last_msg [10];
	logic [7:0]  rep_cnt, win_left;
	logic [31:0] last_time, pair_start;
	logic [7:0]  pair_tab [MAX_PAIRS + 1][8];

	function automatic int find_pair(key_t key, int limit, logic all_dev);
		int lo, hi;
		logic same;
		if (cfg_base) begin
			lo = 2; hi = 6;
		end else begin
			lo = all_dev ? 2 : 0; hi = 7;
		end
		for (int p = limit - 1; p >= 0; p--) begin
			same = 1;
			for (int j = hi; j >= lo; j--)
				if (j != 1 && pair_tab[p][j] != key[j]) same = 0;
			if (same) return p;
		end
		return -1;
	endfunction

	function automatic key_t msg_key();
		key_t k;
		for (int j = 0; j < 8; j++) k[j] = last_msg[j + 2];
		return k;
	endfunction

	function automatic void pair_add();
		key_t k;
		if (pairs >= MAX_PAIRS) return;
		k = msg_key();
		for (int j = 0; j < 8; j++) pair_tab[pairs][j] = k[j];
		if (pairs == 0 || find_pair(k, pairs, 0) < 0) pairs++;
	endfunction

	function automatic void pair_remove();
		int p;
		p = find_pair(msg_key(), pairs, 0);
		if (p < 0) return;
		for (; p + 1 < pairs; p++) pair_tab[p] = pair_tab[p + 1];
		pairs--;
	endfunction

	function automatic logic pairing_allows();
		logic all_dev;
		if (cfg_enforce && pairs == 0) return 0;
		if (pairs == 0) return 1;
		all_dev = (last_msg[3] == CMD_MOOD && last_msg[2] == DEV_ALL) ||
			(last_msg[3] == CMD_OFF && last_msg[0] == PAR_ALLOFF);
		return find_pair(msg_key(), pairs, all_dev) >= 0;
	endfunction

	function automatic logic close_packet(logic [31:0] t);
		logic rep, same;
		rep = 0;
		same = 1;
		for (int k = 0; k < 10; k++) if (last_msg[k] != rx_bytes[k]) same = 0;
		if (cfg_repeats > 0) begin
			if ((t - last_time) / MS_UNIT > {24'd0, cfg_timeout}) rep_cnt = 1;
			else if (same) rep_cnt = rep_cnt + 8'd1;
			else rep_cnt = 1;
		end else begin
			rep_cnt = 0;
		end
		last_time = t;
		last_msg = rx_bytes;
		if (cfg_repeats == 0 || rep_cnt == cfg_repeats) begin
			if (win_left != 0 && (t - pair_start) / MS_UNIT <= {24'd0, win_left}) begin
				if (last_msg[3] == CMD_ON) pair_add();
				else if (last_msg[3] == CMD_OFF) pair_remove();
			end
			rep = pairing_allows();
			win_left = 0;
		end
		return rep;
	endfunction

	function automatic rx_result_t predict_result(edge_req_t r);
		rx_result_t res;
		int ev, bi;
		res = '0;
		if (r.action == ACT_WINDOW) begin
			win_left = r.win;
			pair_start = r.tms;
		end else if (r.action == ACT_CLEAR) begin
			pairs = 0;
		end else if (r.action == ACT_EDGE) begin
			ev = r.level;
			bi = byte_cnt < MSG_LEN ? byte_cnt : 0;
			if (r.dur < 120) ev = ev;
			else if (r.dur < 500) ev += 2;
			else if (r.dur < 2000) ev += 4;
			else if (r.dur > 5000) ev += 6;
			else ev = EV_ILLEGAL;
			case (phase)
				PH_IDLE: if (ev == EV_START) phase = PH_MSG;
				PH_MSG: begin
					if (ev == EV_ONE) begin
						byte_cnt = 0; phase = PH_BYTE;
					end else if (ev != EV_SHORT_HI) phase = PH_IDLE;
				end
				PH_BYTE: begin
					if (ev == EV_ONE) begin
						phase = PH_GET; bit_cnt = 0;
					end else if (ev == EV_ZERO) begin
						phase = PH_GET; bit_cnt = 1; rx_bytes[bi] = 0;
					end else if (ev != EV_SHORT_HI) phase = PH_IDLE;
				end
				default: begin
					if (ev == EV_ONE) begin
						rx_bytes[bi] = {rx_bytes[bi][6:0], 1'b1}; bit_cnt++;
					end else if (ev == EV_ZERO) begin
						rx_bytes[bi] = {rx_bytes[bi][5:0], 2'b10}; bit_cnt += 2;
					end else if (ev != EV_SHORT_HI) phase = PH_IDLE;
					if (bit_cnt >= 8) begin
						byte_cnt = bi + 1;
						bit_cnt = 0;
						if (byte_cnt >= MSG_LEN) begin
							res.done = 1;
							res.rep = close_packet(r.tms);
							phase = PH_IDLE;
						end else begin
							phase = PH_BYTE;
						end
					end
				end
			endcase
		end
		for (int k = 0; k < 8; k++) res.head = {res.head[55:0], last_msg[k]};
		res.tail = {last_msg[8], last_msg[9]};
		res.cnt = pairs[3:0];
		return res;
	endfunction

	// Stimulus building.
	task automatic push_req(logic [1:0] act, logic lvl, logic [15:0] d, logic [7:0] w);
		edge_req_t r;
		r.action = act; r.level = lvl; r.dur = d; r.tms = now_ms; r.win = w;
		pending_reqs.push_back(r);
	endtask

	task automatic push_event(int ev);
		logic [15:0] d;
		case (ev >> 1)
			0: d = $urandom_range(0, 119);
			1: d = $urandom_range(120, 499);
			2: d = $urandom_range(500, 1999);
			3: d = $urandom_range(5001, 65535);
			default: d = $urandom_range(2000, 5000);
		endcase
		now_ms += $urandom_range(0, 2);
		push_req(ACT_EDGE, ev == EV_ILLEGAL ? $urandom_range(0, 1) : ev[0], d, $urandom);
		if ($urandom_range(0, 9) == 0) push_event(EV_SHORT_HI);
	endtask

	function automatic logic encodable(logic [7:0] b);
		for (int i = 0; i < 7; i++) if (!b[i] && !b[i + 1]) return 0;
		return 1;
	endfunction

	function automatic logic [7:0] rand_byte();
		logic [7:0] b;
		do b = $urandom; while (!encodable(b));
		return b;
	endfunction

	task automatic encode_byte(logic [7:0] b);
		int i;
		i = 7;
		if (!b[7]) begin
			ev_list.push_back(EV_ZERO); i = 6;
		end else begin
			ev_list.push_back(EV_ONE);
		end
		while (i >= 0) begin
			if (i > 0 && !b[i - 1]) begin
				ev_list.push_back(EV_ZERO); i -= 2;
			end else begin
				ev_list.push_back(EV_ONE); i -= 1;
			end
		end
	endtask

	task automatic build_packet();
		logic [7:0] msg [10];
		int cnt;
		ev_list.delete();
		ev_list.push_back(EV_START);
		ev_list.push_back(EV_ONE);
		if ($urandom_range(0, 6) == 0) begin
			// Free-running bit events, which may place a two-bit event at the last bit.
			for (int k = 0; k < 10; k++) begin
				cnt = $urandom_range(0, 1);
				ev_list.push_back(cnt ? EV_ZERO : EV_ONE);
				while (cnt < 8) begin
					if ($urandom_range(0, 1)) begin
						ev_list.push_back(EV_ZERO); cnt += 2;
					end else begin
						ev_list.push_back(EV_ONE); cnt += 1;
					end
				end
			end
			return;
		end
		msg = dev_pool[$urandom_range(0, 3)];
		case ($urandom_range(0, 4))
			0, 1: msg[3] = CMD_ON;
			2: msg[3] = CMD_OFF;
			3: msg[3] = CMD_MOOD;
			default: msg[3] = rand_byte();
		endcase
		msg[1] = rand_byte();
		if ($urandom_range(0, 4) == 0) msg[0] = PAR_ALLOFF;
		if ($urandom_range(0, 4) == 0) msg[2] = DEV_ALL;
		for (int k = 0; k < 10; k++) encode_byte(msg[k]);
	endtask

	task automatic gen_random(int n);
		int start, r, reps;
		start = pending_reqs.size();
		while (pending_reqs.size() - start < n) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				push_event($urandom_range(0, 8));
			end else if (r < 14) begin
				push_req(ACT_WINDOW, $urandom, $urandom,
					$urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 40));
			end else if (r < 16) begin
				push_req(ACT_CLEAR, $urandom, $urandom, $urandom);
			end else if (r < 18) begin
				push_req(2'd3, $urandom, $urandom, $urandom);
			end else if (r < 20) begin
				now_ms = $urandom;
			end else begin
				build_packet();
				reps = $urandom_range(1, 4);
				for (int p = 0; p < reps; p++) begin
					now_ms += $urandom_range(0, 9) == 0 ? $urandom_range(0, 6000)
						: $urandom_range(0, 300);
					if ($urandom_range(0, 11) == 0) begin
						foreach (ev_list[k])
							if (k < 30) push_event(ev_list[k]);
						push_event(EV_ILLEGAL);
					end else begin
						foreach (ev_list[k]) push_event(ev_list[k]);
					end
				end
			end
		end
		while (pending_reqs.size() - start > n) void'(pending_reqs.pop_back());
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0);
		repeat (8 + 6 * MAX_PAIRS + 10) @(posedge clk);
	endtask

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			REG_REPEATS: cfg_repeats = val[7:0];
			REG_TIMEOUT: cfg_timeout = val[7:0];
			REG_ENFORCE: cfg_enforce = val[0];
			default: cfg_base = val[0];
		endcase
	endtask

	task automatic set_config(int rn, int rt, int en, int bo);
		reg_write(REG_REPEATS, rn);
		reg_write(REG_TIMEOUT, rt);
		reg_write(REG_ENFORCE, en);
		reg_write(REG_BASE, bo);
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("Mismatch at cycle %0d on %s: got %h, expected %h", cycles, what, got, want);
	endtask

	// Request driver with bursts and gaps.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				rx_result_t res;
				res = predict_result(drv_req);
				expected_results.push_back(res);
				accepted++;
				packets_seen += res.done;
				packets_reported += res.rep;
				if (pairs > max_pairs_seen) max_pairs_seen = pairs;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 0;
				end else if (pending_reqs.size() != 0) begin
					drv_req = pending_reqs.pop_front();
					s_tvalid <= 1;
					s_tuser <= drv_req.action;
					s_tdata <= {7'd0, drv_req.win, drv_req.tms, drv_req.dur, drv_req.level};
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 30);
						gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
					end
				end else begin
					s_tvalid <= 0;
				end
			end
		end
	end

	// Result receiver with changing stall patterns.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cycles % 256 == 0) stall_mode = $urandom_range(0, 2);
			case (stall_mode)
				0: m_tready <= 1;
				1: m_tready <= $urandom_range(0, 1);
				default: m_tready <= $urandom_range(0, 4) == 0;
			endcase
		end
	end

	always @(posedge clk) begin
		rx_result_t got, want;
		cycles++;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[85:0];
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", m_tdata[63:0], '0);
			end else begin
				want = expected_results.pop_front();
				if (got.done !== want.done) report_mismatch("packet_done", got.done, want.done);
				if (got.rep !== want.rep) report_mismatch("reported", got.rep, want.rep);
				if (got.head !== want.head) report_mismatch("msg_head", got.head, want.head);
				if (got.tail !== want.tail) report_mismatch("msg_tail", got.tail, want.tail);
				if (got.cnt !== want.cnt) report_mismatch("pair_count", got.cnt, want.cnt);
			end
		end
		if (cycles >= 1000000) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		cfg_repeats = 2; cfg_timeout = 20; cfg_enforce = 0; cfg_base = 0;
		phase = PH_IDLE; bit_cnt = 0; byte_cnt = 0; pairs = 0;
		rep_cnt = 0; win_left = 0; last_time = 0; pair_start = 0;
		for (int k = 0; k < 10; k++) begin
			rx_bytes[k] = 0; last_msg[k] = 0;
		end
		for (int p = 0; p < 4; p++)
			for (int k = 0; k < 10; k++) dev_pool[p][k] = rand_byte();
		now_ms = 32'hFFFF_FF00;
		repeat (12) @(posedge clk);
		arst_n <= 1;

		// Directed: unused action, window and clear, class boundaries, illegal event.
		push_req(2'd3, 1, 16'hFFFF, 8'hFF);
		push_req(ACT_WINDOW, 0, 0, 8'hFF);
		push_req(ACT_CLEAR, 1, 16'hFFFF, 8'h00);
		push_req(ACT_EDGE, 0, 16'd0, 0);
		push_req(ACT_EDGE, 1, 16'hFFFF, 0);
		push_req(ACT_EDGE, 1, 16'd2000, 0);
		push_req(ACT_EDGE, 1, 16'd5001, 0);
		push_req(ACT_EDGE, 1, 16'd120, 0);
		push_req(ACT_EDGE, 1, 16'd499, 0);
		push_req(ACT_EDGE, 1, 16'd500, 0);
		push_req(ACT_EDGE, 0, 16'd1999, 0);
		push_req(ACT_EDGE, 1, 16'd5000, 0);
		push_req(ACT_EDGE, 1, 16'd119, 0);
		gen_random(250);
		wait_idle();

		set_config(0, 0, 0, 0);
		gen_random(300);
		wait_idle();
		set_config(1, 255, 1, 1);
		gen_random(300);
		wait_idle();
		set_config(3, 5, 1, 0);
		gen_random(300);
		wait_idle();
		set_config(255, 0, 0, 1);
		gen_random(100);
		wait_idle();
		set_config(2, 20, 0, 0);
		gen_random(200);
		wait_idle();

		$display("Requests accepted: %0d, packets completed: %0d, reported: %0d",
			accepted, packets_seen, packets_reported);
		$display("Largest pairing table: %0d entries", max_pairs_seen);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
